// ----- design/dbep_pkg.sv -----
// Shared widths, result codes and byte constants for the directory block entry parser.
package dbep_pkg;

	localparam int OFS_W = 17;  // block offsets, up to 64 KiB inclusive
	localparam int RL_W  = 9;   // used record length, at most 272 bytes

	// offsets at or above this are past the block and ignored
	localparam logic [OFS_W-1:0] BLOCK_BYTES = 17'd4096;

	// register indexes on the config port
	localparam logic [1:0] CFG_ENTRIES_START     = 2'd0;
	localparam logic [1:0] CFG_ENTRIES_END       = 2'd1;
	localparam logic [1:0] CFG_FILE_TYPE_PRESENT = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_ENTRY    = 2'd0;
	localparam logic [1:0] KIND_ERROR    = 2'd1;
	localparam logic [1:0] KIND_FINISHED = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_SHORT_FREE  = 3'd1;
	localparam logic [2:0] ERR_FREE_LEN    = 3'd2;
	localparam logic [2:0] ERR_SHORT_ENTRY = 3'd3;
	localparam logic [2:0] ERR_OVERRUN     = 3'd4;

	localparam logic [15:0] TAG_UNUSED = 16'hFFFF;
	localparam logic [7:0]  DOT_CHAR   = 8'h2E;

endpackage

// ----- design/directory_block_entry_parser.sv -----
// Directory block entry parser: walks records of a streamed directory block, reports entries, errors and finish.
// An accepted item is registered in the input register, then parsed; its result, if any,
//   goes to the output register. Throughput: one item per cycle unless result_stall holds
//   a result, set by the single parse stage between input register and result register.
// Reset (arst_n low) clears all parse state, loads entries_start 16, entries_end 4096,
//   file_type_present 0; items are ignored until one arrives flagged first_of_block.
module directory_block_entry_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write port
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [dbep_pkg::OFS_W-1:0]   cfg_data,
	// byte channel
	input  logic                         byte_valid,
	output logic                         byte_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         first_of_block,
	// result channel
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [1:0]                   kind,
	output logic [63:0]                  entry_inode,
	output logic [15:0]                  name_offset,
	output logic [7:0]                   name_length,
	output logic [2:0]                   error_code
);
	import dbep_pkg::*;

	// Parse phases:
	//   IDLE - no block yet, or halted
	//   SEEK - waiting for the byte offset to reach the record cursor
	//   HEAD - first two bytes of a record (tag or inode high bytes)
	//   FREE - length field of an unused record
	//   USED - inode bytes up to the name length byte
	//   NAME - name, file type, tag and padding of a used record
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_HEAD,
		PH_FREE,
		PH_USED,
		PH_NAME
	} phase_t;

	localparam logic [1:0] CUR_OK    = 2'd0;
	localparam logic [1:0] CUR_FIN   = 2'd1;
	localparam logic [1:0] CUR_SHORT = 2'd2;

	// Check a new record cursor against the end of the record area.
	function automatic logic [1:0] cursor_eval(input logic [OFS_W-1:0] c,
	                                           input logic [OFS_W-1:0] e);
		logic [OFS_W-1:0] left;
		left = e - c;
		if (c >= e)
			return CUR_FIN;
		else if (left < 17'd4)
			return CUR_SHORT;
		else
			return CUR_OK;
	endfunction

	// config registers
	logic [OFS_W-1:0] entries_start_q;
	logic [OFS_W-1:0] entries_end_q;
	logic             ft_present_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// parse state
	logic [OFS_W-1:0] bo_q;      // byte offset in block
	logic [OFS_W-1:0] rs_q;      // record cursor
	logic [RL_W-1:0]  rl_q;      // padded length of current used record
	phase_t           ph_q;
	logic [63:0]      inode_q;
	logic [15:0]      tag_q;
	logic [7:0]       nsize_q;
	logic             dot_q;
	logic             halt_q;

	// next state
	logic [OFS_W-1:0] n_bo, n_rs;
	logic [RL_W-1:0]  n_rl;
	phase_t           n_ph;
	logic [63:0]      n_inode;
	logic [15:0]      n_tag;
	logic [7:0]       n_nsize;
	logic             n_dot;
	logic             n_halt;

	// candidate result
	logic        hit;
	logic [1:0]  r_kind;
	logic [63:0] r_inode;
	logic [15:0] r_off;
	logic [7:0]  r_len;
	logic [2:0]  r_err;

	// parse scratch
	logic             go;
	logic             done;
	logic [OFS_W-1:0] rel;
	logic [15:0]      tag_sh;
	logic [OFS_W:0]   space;
	logic             space_ok;
	logic [9:0]       sz_sum;
	logic [RL_W-1:0]  sz;
	logic [OFS_W-1:0] cval;
	logic [OFS_W-1:0] off_full;
	logic [1:0]       cchk;

	logic adv;
	logic fire;

	// the result register frees up when empty or being drained
	assign adv        = !result_valid || !result_stall;
	assign fire       = valid_s1 && adv;
	assign byte_stall = valid_s1 && !adv;

	//------------------------------------------------------------------
	// parse logic for the byte in the input register
	//------------------------------------------------------------------
	always_comb begin
		n_bo    = bo_q;
		n_rs    = rs_q;
		n_rl    = rl_q;
		n_ph    = ph_q;
		n_inode = inode_q;
		n_tag   = tag_q;
		n_nsize = nsize_q;
		n_dot   = dot_q;
		n_halt  = halt_q;

		hit     = 1'b0;
		r_kind  = KIND_ENTRY;
		r_inode = '0;
		r_off   = '0;
		r_len   = '0;
		r_err   = ERR_NONE;

		go       = 1'b0;
		done     = 1'b0;
		rel      = '0;
		tag_sh   = '0;
		space    = '0;
		space_ok = 1'b0;
		sz_sum   = '0;
		sz       = '0;
		cval     = '0;
		off_full = '0;
		cchk     = CUR_OK;

		// flagged byte restarts the block and places the cursor at entries_start
		if (first_s1) begin
			n_bo    = '0;
			n_rl    = '0;
			n_inode = '0;
			n_tag   = '0;
			n_nsize = '0;
			n_dot   = 1'b0;
			n_halt  = 1'b0;
			n_rs    = entries_start_q;
			cchk    = cursor_eval(entries_start_q, entries_end_q);
			if (cchk == CUR_FIN) begin
				n_halt = 1'b1;
				n_ph   = PH_IDLE;
				hit    = 1'b1;
				r_kind = KIND_FINISHED;
			end else if (cchk == CUR_SHORT) begin
				n_halt = 1'b1;
				n_ph   = PH_IDLE;
				hit    = 1'b1;
				r_kind = KIND_ERROR;
				r_err  = ERR_SHORT_FREE;
			end else begin
				n_ph = PH_SEEK;
			end
		end

		if (n_bo < BLOCK_BYTES) begin
			if (!n_halt && n_ph != PH_IDLE && !hit) begin
				go = 1'b1;
				if (n_ph == PH_SEEK) begin
					if (n_bo != n_rs)
						go = 1'b0;
					else
						n_ph = PH_HEAD;
				end
				if (go) begin
					rel      = n_bo - n_rs;
					tag_sh   = {n_tag[7:0], byte_s1};
					space    = {1'b0, entries_end_q} - {1'b0, n_rs};
					space_ok = !space[OFS_W];   // end not below cursor
					off_full = n_rs + 17'd9;
					if (rel < 17'd8)
						n_inode = {n_inode[55:0], byte_s1};

					case (n_ph)
						PH_HEAD: begin
							n_tag = tag_sh;
							if (rel == 17'd1) begin
								if (tag_sh == TAG_UNUSED) begin
									n_ph = PH_FREE;
								end else if (space_ok && space[OFS_W-1:0] < 17'd9) begin
									n_halt = 1'b1;
									n_ph   = PH_IDLE;
									hit    = 1'b1;
									r_kind = KIND_ERROR;
									r_err  = ERR_SHORT_ENTRY;
								end else begin
									n_ph = PH_USED;
								end
							end
						end
						PH_FREE: begin
							n_tag = tag_sh;
							if (rel == 17'd3) begin
								if (tag_sh < 16'd4) begin
									n_halt = 1'b1;
									n_ph   = PH_IDLE;
									hit    = 1'b1;
									r_kind = KIND_ERROR;
									r_err  = ERR_FREE_LEN;
								end else begin
									cval = n_rs + {1'b0, tag_sh};
									done = 1'b1;   // cursor move below
								end
							end
						end
						PH_USED: begin
							if (rel >= 17'd8) begin
								n_nsize = byte_s1;
								n_dot   = 1'b0;
								// 9 header + name + 2 tag + type byte, rounded up to 8
								sz_sum  = {2'b00, byte_s1} + 10'd18 + {9'd0, ft_present_q};
								sz      = {sz_sum[8:3], 3'b000};
								n_rl    = sz;
								if (space_ok && {8'd0, sz} > space[OFS_W-1:0]) begin
									n_halt = 1'b1;
									n_ph   = PH_IDLE;
									hit    = 1'b1;
									r_kind = KIND_ERROR;
									r_err  = ERR_OVERRUN;
								end else begin
									n_ph = PH_NAME;
									if (byte_s1 == 8'd0 || byte_s1 > 8'd2) begin
										hit     = 1'b1;
										r_kind  = KIND_ENTRY;
										r_inode = n_inode;
										r_off   = off_full[15:0];
										r_len   = byte_s1;
									end
								end
							end
						end
						PH_NAME: begin
							// one- and two-byte names are held back to filter '.' and '..'
							if (rel == 17'd9 && n_nsize == 8'd1) begin
								if (byte_s1 != DOT_CHAR) begin
									hit     = 1'b1;
									r_inode = n_inode;
									r_off   = off_full[15:0];
									r_len   = n_nsize;
								end
							end else if (rel == 17'd9 && n_nsize == 8'd2) begin
								n_dot = (byte_s1 == DOT_CHAR);
								if (rel + 17'd1 == {8'd0, n_rl}) begin
									cval = n_rs + {8'd0, n_rl};
									done = 1'b1;
								end
							end else if (rel == 17'd10 && n_nsize == 8'd2) begin
								if (!(n_dot && byte_s1 == DOT_CHAR)) begin
									hit     = 1'b1;
									r_inode = n_inode;
									r_off   = off_full[15:0];
									r_len   = n_nsize;
								end
							end else if (rel + 17'd1 == {8'd0, n_rl}) begin
								cval = n_rs + {8'd0, n_rl};
								done = 1'b1;
							end
						end
						default: ;
					endcase

					// next record cursor
					if (done) begin
						n_rs = cval;
						cchk = cursor_eval(cval, entries_end_q);
						if (cchk == CUR_FIN) begin
							n_halt = 1'b1;
							n_ph   = PH_IDLE;
							hit    = 1'b1;
							r_kind = KIND_FINISHED;
						end else if (cchk == CUR_SHORT) begin
							n_halt = 1'b1;
							n_ph   = PH_IDLE;
							hit    = 1'b1;
							r_kind = KIND_ERROR;
							r_err  = ERR_SHORT_FREE;
						end else begin
							n_ph = PH_SEEK;
						end
					end
				end
			end
			if (n_ph != PH_IDLE || n_halt)
				n_bo = n_bo + 17'd1;
		end
	end

	//------------------------------------------------------------------
	// config registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_start_q <= 17'd16;
			entries_end_q   <= 17'd4096;
			ft_present_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ENTRIES_START:     entries_start_q <= cfg_data;
				CFG_ENTRIES_END:       entries_end_q   <= cfg_data;
				CFG_FILE_TYPE_PRESENT: ft_present_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// input register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			first_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
			byte_s1  <= data_byte;
			first_s1 <= first_of_block;
		end
	end

	//------------------------------------------------------------------
	// parse state: advances once per byte leaving the input register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bo_q    <= '0;
			rs_q    <= '0;
			rl_q    <= '0;
			ph_q    <= PH_IDLE;
			inode_q <= '0;
			tag_q   <= '0;
			nsize_q <= '0;
			dot_q   <= 1'b0;
			halt_q  <= 1'b0;
		end else if (fire) begin
			bo_q    <= n_bo;
			rs_q    <= n_rs;
			rl_q    <= n_rl;
			ph_q    <= n_ph;
			inode_q <= n_inode;
			tag_q   <= n_tag;
			nsize_q <= n_nsize;
			dot_q   <= n_dot;
			halt_q  <= n_halt;
		end
	end

	//------------------------------------------------------------------
	// result register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= fire && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hit) begin
			kind         <= r_kind;
			entry_inode  <= r_inode;
			name_offset  <= r_off;
			name_length  <= r_len;
			error_code   <= r_err;
		end
	end

`ifndef SYNTHESIS
	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (result_valid && result_stall))
		else $error("byte stall without a blocked result");

	// error code set exactly for error results
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match result kind");

	// an error or finish result halts the parser
	a_halt_after: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && hit && r_kind != KIND_ENTRY) |=> (halt_q && ph_q == PH_IDLE))
		else $error("parser not halted after error or finish");

	// a halted parser never sits in an active phase
	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> (ph_q == PH_IDLE))
		else $error("halted parser in active phase");
`endif

endmodule
